/* hdl/hhp_pkg.sv */
// Shared types, register codes and helpers for the hex hole plate transit block.
`default_nettype none
package hhp_pkg;

    localparam int DIV_NW = 47;
    localparam int DIV_DW = 32;

    localparam logic [29:0] SQRT3_HALF_Q30 = 30'd929887697;

    typedef enum logic [2:0] {
        REG_HOLE_PITCH      = 3'd0,
        REG_HOLE_RADIUS     = 3'd1,
        REG_PLANE_Z         = 3'd2,
        REG_PLATE_THICKNESS = 3'd3,
        REG_CAPTURE_WINDOW  = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_PASS = 2'd1,
        ACT_KILL = 2'd2
    } action_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } in_t;

    typedef struct packed {
        action_t            action;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
    } out_t;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -52'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hdl/hhp_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module hhp_div #(
    parameter int NW = hhp_pkg::DIV_NW,
    parameter int DW = hhp_pkg::DIV_DW
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic      [NW-1:0] quo,
    output logic      [DW-1:0] rem
);
    import hhp_pkg::*;

    logic [NW-1:0] nq_reg  [NW];
    logic [DW-1:0] rem_reg [NW];
    logic [DW-1:0] den_reg [NW];

    for (genvar g = 0; g < NW; g++) begin : g_stage
        logic [NW-1:0] nq_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;

        if (g == 0) begin : g_first
            assign nq_in  = num;
            assign rem_in = '0;
            assign den_in = den;
        end else begin : g_next
            assign nq_in  = nq_reg[g-1];
            assign rem_in = rem_reg[g-1];
            assign den_in = den_reg[g-1];
        end

        assign trial = {rem_in, nq_in[NW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign ge    = trial >= {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                nq_reg[g]  <= {nq_in[NW-2:0], ge};
                den_reg[g] <= den_in;
            end
        end
    end

    assign quo = nq_reg[NW-1];
    assign rem = rem_reg[NW-1];

endmodule
`default_nettype wire

/* hdl/hex_hole_plate_transit.sv */
// Top level of the hex hole plate transit pipeline.
// Takes one photon beat per cycle when the output side does not stall and returns
// one result beat per photon, in order. Four 47-step restoring dividers (row index,
// column index and the x and y shift through the plate) run side by side; around
// them sit an input stage, an operand stage and four stages for lattice centres,
// offsets, squares and the final decision. The whole pipe holds on a stall of the
// result channel.
`default_nettype none
module hex_hole_plate_transit (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire hhp_pkg::in_t s_payload,
    output logic              m_valid,
    input  wire logic         m_ready,
    output hhp_pkg::out_t     m_payload,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);
    import hhp_pkg::*;

    localparam int NW = DIV_NW;
    localparam int DW = DIV_DW;
    localparam logic signed [51:0] RANGE = 52'sd4294967296;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic inwin;
        logic rowneed;
        logic x_nonpos;
        logic y_neg;
        logic uz_zero;
        logic uz_pos;
        logic px_neg;
        logic py_neg;
    } side_t;

    function automatic logic [32:0] mag_chk(input logic signed [51:0] v);
        logic signed [51:0] a;
        logic               ok;
        a  = v[51] ? -v : v;
        ok = (v > -RANGE) && (v < RANGE);
        return {ok, a[31:0]};
    endfunction

    // configuration
    logic [30:0]        hole_pitch_reg;
    logic [30:0]        hole_radius_reg;
    logic signed [31:0] plane_z_reg;
    logic [30:0]        plate_thickness_reg;
    logic [30:0]        capture_window_reg;
    logic [30:0]        sy_reg;
    logic [30:0]        p_eff;
    logic [60:0]        sy_prod;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hole_pitch_reg      <= 31'd58982;
            hole_radius_reg     <= 31'd16384;
            plane_z_reg         <= '0;
            plate_thickness_reg <= 31'd26214;
            capture_window_reg  <= 31'd655;
        end else if (cfg_wr_en) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_HOLE_PITCH:      hole_pitch_reg      <= cfg_wdata[30:0];
                REG_HOLE_RADIUS:     hole_radius_reg     <= cfg_wdata[30:0];
                REG_PLANE_Z:         plane_z_reg         <= cfg_wdata;
                REG_PLATE_THICKNESS: plate_thickness_reg <= cfg_wdata[30:0];
                REG_CAPTURE_WINDOW:  capture_window_reg  <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    assign p_eff   = (hole_pitch_reg == '0) ? 31'd1 : hole_pitch_reg;
    assign sy_prod = 61'(p_eff) * 61'(SQRT3_HALF_Q30);

    always_ff @(posedge aclk) begin
        sy_reg <= (sy_prod[60:30] == '0) ? 31'd1 : sy_prod[60:30];
    end

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // stage 0: input register
    logic v0_reg;
    in_t  in0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s_valid) begin
            in0_reg <= s_payload;
        end
    end

    // stage 1: window test, magnitudes and divider operands
    side_t              side1_next;
    logic [31:0]        ax1, ay1, rowdiv1;
    logic signed [33:0] z34, lo34, hi34;
    logic [30:0]        hy1;
    logic signed [47:0] prx1, pry1, apx1, apy1;
    logic [15:0]        az1;

    always_comb begin
        ax1  = in0_reg.pos_x[31] ? (~in0_reg.pos_x + 32'd1) : in0_reg.pos_x;
        ay1  = in0_reg.pos_y[31] ? (~in0_reg.pos_y + 32'd1) : in0_reg.pos_y;
        z34  = 34'(in0_reg.pos_z);
        lo34 = 34'(plane_z_reg) - $signed({3'b000, capture_window_reg});
        hi34 = 34'(plane_z_reg) + $signed({3'b000, capture_window_reg});
        hy1  = sy_reg >> 1;
        rowdiv1 = ay1 - {1'b0, hy1};
        prx1 = $signed({17'd0, plate_thickness_reg}) * 48'(in0_reg.dir_x);
        pry1 = $signed({17'd0, plate_thickness_reg}) * 48'(in0_reg.dir_y);
        apx1 = prx1[47] ? -prx1 : prx1;
        apy1 = pry1[47] ? -pry1 : pry1;
        az1  = in0_reg.dir_z[15] ? (~in0_reg.dir_z + 16'd1) : in0_reg.dir_z;
        side1_next.x        = in0_reg.pos_x;
        side1_next.y        = in0_reg.pos_y;
        side1_next.z        = in0_reg.pos_z;
        side1_next.inwin    = (z34 > lo34) && (z34 < hi34);
        side1_next.rowneed  = ay1 >= {1'b0, hy1};
        side1_next.x_nonpos = in0_reg.pos_x[31] || (in0_reg.pos_x == '0);
        side1_next.y_neg    = in0_reg.pos_y[31];
        side1_next.uz_zero  = in0_reg.dir_z == '0;
        side1_next.uz_pos   = !in0_reg.dir_z[15] && (in0_reg.dir_z != '0);
        side1_next.px_neg   = prx1[47];
        side1_next.py_neg   = pry1[47];
    end

    logic          v1_reg;
    side_t         side1_reg;
    logic [NW-1:0] nrow_reg, ncol_reg, nsx_reg, nsy_reg;
    logic [DW-1:0] drow_reg, dcol_reg, dsh_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side1_next;
            nrow_reg  <= NW'(rowdiv1);
            ncol_reg  <= NW'(ax1);
            nsx_reg   <= apx1[NW-1:0];
            nsy_reg   <= apy1[NW-1:0];
            drow_reg  <= DW'(sy_reg);
            dcol_reg  <= DW'(p_eff);
            dsh_reg   <= DW'(az1);
        end
    end

    // dividers
    logic [NW-1:0] qrow, qcol, qsx, qsy;
    logic [DW-1:0] rrow, rcol, rsx, rsy;

    hhp_div #(.NW(NW), .DW(DW)) u_div_row (
        .aclk(aclk), .en(en), .num(nrow_reg), .den(drow_reg), .quo(qrow), .rem(rrow)
    );
    hhp_div #(.NW(NW), .DW(DW)) u_div_col (
        .aclk(aclk), .en(en), .num(ncol_reg), .den(dcol_reg), .quo(qcol), .rem(rcol)
    );
    hhp_div #(.NW(NW), .DW(DW)) u_div_sx (
        .aclk(aclk), .en(en), .num(nsx_reg), .den(dsh_reg), .quo(qsx), .rem(rsx)
    );
    hhp_div #(.NW(NW), .DW(DW)) u_div_sy (
        .aclk(aclk), .en(en), .num(nsy_reg), .den(dsh_reg), .quo(qsy), .rem(rsy)
    );

    logic  vd_reg   [NW];
    side_t sided_reg[NW];

    for (genvar g = 0; g < NW; g++) begin : g_delay
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[g] <= 1'b0;
            end else if (en) begin
                vd_reg[g] <= (g == 0) ? v1_reg : vd_reg[(g == 0) ? 0 : g-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sided_reg[g] <= (g == 0) ? side1_reg : sided_reg[(g == 0) ? 0 : g-1];
            end
        end
    end

    // stage A: lattice centres and exit point
    side_t              sd;
    logic [32:0]        nrow;
    logic [63:0]        ycp, xcp;
    logic [33:0]        mcol;
    logic [32:0]        two_r;
    logic               odd;
    logic signed [47:0] dxs, dys;
    logic signed [48:0] xf_next, yf_next;
    logic signed [34:0] yc_next;
    logic signed [36:0] xc2_next;

    always_comb begin
        sd    = sided_reg[NW-1];
        odd   = sd.rowneed && !qrow[0];
        nrow  = 33'(qrow[31:0]) + 33'd1;
        ycp   = sd.rowneed ? (64'(nrow) * 64'(sy_reg)) : 64'd0;
        two_r = {rcol, 1'b0};
        if (odd) begin
            mcol = (two_r >= 33'(p_eff)) ? ({1'b0, qcol[31:0], 1'b0} + 34'd2)
                                         : {1'b0, qcol[31:0], 1'b0};
        end else begin
            mcol = {1'b0, qcol[31:0], 1'b1};
        end
        xcp      = 64'(mcol) * 64'(p_eff);
        yc_next  = sd.y_neg ? -$signed({1'b0, ycp[33:0]}) : $signed({1'b0, ycp[33:0]});
        xc2_next = sd.x_nonpos ? -$signed({1'b0, xcp[35:0]}) : $signed({1'b0, xcp[35:0]});
        dxs      = sd.px_neg ? -$signed({1'b0, qsx}) : $signed({1'b0, qsx});
        dys      = sd.py_neg ? -$signed({1'b0, qsy}) : $signed({1'b0, qsy});
        xf_next  = 49'(sd.x) + 49'(dxs);
        yf_next  = 49'(sd.y) + 49'(dys);
    end

    logic               a_v_reg;
    side_t              a_side_reg;
    logic signed [34:0] a_yc_reg;
    logic signed [36:0] a_xc2_reg;
    logic signed [48:0] a_xf_reg, a_yf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= vd_reg[NW-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= sd;
            a_yc_reg   <= yc_next;
            a_xc2_reg  <= xc2_next;
            a_xf_reg   <= xf_next;
            a_yf_reg   <= yf_next;
        end
    end

    // stage B: doubled offsets, range checks and radius limit
    logic [32:0] mxi, myi, mxo, myo;
    logic [31:0] r2;

    always_comb begin
        mxi = mag_chk(52'(a_side_reg.x) * 52'sd2 - 52'(a_xc2_reg));
        myi = mag_chk((52'(a_side_reg.y) - 52'(a_yc_reg)) * 52'sd2);
        mxo = mag_chk(52'(a_xf_reg) * 52'sd2 - 52'(a_xc2_reg));
        myo = mag_chk((52'(a_yf_reg) - 52'(a_yc_reg)) * 52'sd2);
        r2  = {hole_radius_reg, 1'b0};
    end

    logic               b_v_reg;
    side_t              b_side_reg;
    logic signed [48:0] b_xf_reg, b_yf_reg;
    logic               b_oki_reg, b_oko_reg;
    logic [31:0]        b_axi_reg, b_ayi_reg, b_axo_reg, b_ayo_reg;
    logic [63:0]        b_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (en) begin
            b_v_reg <= a_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_side_reg <= a_side_reg;
            b_xf_reg   <= a_xf_reg;
            b_yf_reg   <= a_yf_reg;
            b_oki_reg  <= mxi[32] && myi[32];
            b_oko_reg  <= mxo[32] && myo[32];
            b_axi_reg  <= mxi[31:0];
            b_ayi_reg  <= myi[31:0];
            b_axo_reg  <= mxo[31:0];
            b_ayo_reg  <= myo[31:0];
            b_lim_reg  <= 64'(r2) * 64'(r2);
        end
    end

    // stage C: squares
    logic               c_v_reg;
    side_t              c_side_reg;
    logic signed [48:0] c_xf_reg, c_yf_reg;
    logic               c_oki_reg, c_oko_reg;
    logic [63:0]        c_sxi_reg, c_syi_reg, c_sxo_reg, c_syo_reg, c_lim_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_v_reg <= 1'b0;
        end else if (en) begin
            c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg <= b_side_reg;
            c_xf_reg   <= b_xf_reg;
            c_yf_reg   <= b_yf_reg;
            c_oki_reg  <= b_oki_reg;
            c_oko_reg  <= b_oko_reg;
            c_sxi_reg  <= 64'(b_axi_reg) * 64'(b_axi_reg);
            c_syi_reg  <= 64'(b_ayi_reg) * 64'(b_ayi_reg);
            c_sxo_reg  <= 64'(b_axo_reg) * 64'(b_axo_reg);
            c_syo_reg  <= 64'(b_ayo_reg) * 64'(b_ayo_reg);
            c_lim_reg  <= b_lim_reg;
        end
    end

    // stage D: decision and output register
    logic               hit_in, hit_out;
    logic signed [33:0] oz_up, oz_dn;
    out_t               m_payload_next;

    always_comb begin
        hit_in  = c_oki_reg && (c_sxi_reg < c_lim_reg) && (c_syi_reg < c_lim_reg - c_sxi_reg);
        hit_out = c_oko_reg && (c_sxo_reg < c_lim_reg) && (c_syo_reg < c_lim_reg - c_sxo_reg);
        oz_up   = 34'(plane_z_reg) + $signed({3'b000, plate_thickness_reg});
        oz_dn   = 34'(plane_z_reg) - $signed({3'b000, plate_thickness_reg});
        m_payload_next.action = ACT_NONE;
        m_payload_next.new_x  = c_side_reg.x;
        m_payload_next.new_y  = c_side_reg.y;
        m_payload_next.new_z  = c_side_reg.z;
        if (c_side_reg.inwin && hit_in) begin
            if (c_side_reg.uz_zero || !hit_out) begin
                m_payload_next.action = ACT_KILL;
            end else begin
                m_payload_next.action = ACT_PASS;
                m_payload_next.new_x  = sat32(52'(c_xf_reg));
                m_payload_next.new_y  = sat32(52'(c_yf_reg));
                m_payload_next.new_z  = c_side_reg.uz_pos ? sat32(52'(oz_up))
                                                          : sat32(52'(oz_dn));
            end
        end
    end

    logic m_valid_reg;
    out_t m_payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= c_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    a_window_untouched: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_v_reg && en && !c_side_reg.inwin) |=>
            (m_valid && m_payload.action == ACT_NONE && m_payload.new_z == $past(c_side_reg.z)))
        else $error("photon outside the window was modified");

    a_flat_dir_no_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_v_reg && en && c_side_reg.uz_zero) |=> (m_payload.action != ACT_PASS))
        else $error("photon with zero dir_z passed");

    a_pass_z: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.action == ACT_PASS) |->
            (m_payload.new_z == sat32(52'(oz_up)) || m_payload.new_z == sat32(52'(oz_dn))))
        else $error("passed photon exit z off the plate face");

    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result beat right after reset");

endmodule
`default_nettype wire

/* bench/hex_hole_plate_transit_test.sv */
// Testbench for the hex hole plate transit block: directed and random photons checked in order.
`timescale 1ns / 100ps
`default_nettype none
module hex_hole_plate_transit_test;
    import hhp_pkg::*;

    class transit_scoreboard;
        out_t expected_q[$];
        int   fails;
        int   passed_cnt;
        int   killed_cnt;
        int   checked_cnt;
        logic [30:0] pitch, radius, thick, window;
        logic signed [31:0] plane;

        function void set_reset_regs();
            pitch  = 31'd58982;
            radius = 31'd16384;
            plane  = 32'sd0;
            thick  = 31'd26214;
            window = 31'd655;
        endfunction

        function void write_reg(reg_idx_t idx, logic [31:0] val);
            case (idx)
                REG_HOLE_PITCH:      pitch = val[30:0];
                REG_HOLE_RADIUS:     radius = val[30:0];
                REG_PLANE_Z:         plane = val;
                REG_PLATE_THICKNESS: thick = val[30:0];
                REG_CAPTURE_WINDOW:  window = val[30:0];
                default: ;
            endcase
        endfunction

        function bit in_hole(longint dx2, longint dy2);
            longint unsigned ax, ay, lim, sx;
            if (dx2 >= 64'sd4294967296 || dx2 <= -64'sd4294967296 ||
                dy2 >= 64'sd4294967296 || dy2 <= -64'sd4294967296) return 0;
            ax = dx2 < 0 ? -dx2 : dx2;
            ay = dy2 < 0 ? -dy2 : dy2;
            lim = (2 * longint'(radius)) * (2 * longint'(radius));
            sx = ax * ax;
            return sx < lim && ay * ay < lim - sx;
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return v[31:0];
        endfunction

        function void note_photon(in_t b);
            longint x, y, z, ux, uy, uz, p, sy, hy, ay, ax, yc, xc2, n, nx, t, az, xf, yf, w;
            longint ox, oy, oz;
            longint unsigned prod;
            bit odd;
            out_t r;
            x = b.pos_x; y = b.pos_y; z = b.pos_z;
            ux = b.dir_x; uy = b.dir_y; uz = b.dir_z;
            p = pitch == 0 ? 1 : pitch;
            w = window;
            ox = x; oy = y; oz = z; odd = 0;
            r.action = ACT_NONE;
            if (z > plane - w && z < plane + w) begin
                prod = longint'(p) * 64'd929887697;
                sy = prod >> 30;
                if (sy < 1) sy = 1;
                hy = sy / 2;
                ay = y < 0 ? -y : y;
                ax = x < 0 ? -x : x;
                if (ay < hy) begin
                    yc = 0;
                end else begin
                    n = (ay - hy) / sy + 1;
                    odd = n[0];
                    yc = y < 0 ? -(n * sy) : n * sy;
                end
                if (odd) begin
                    if (2 * ax < p) begin
                        xc2 = 0;
                    end else begin
                        nx = (2 * ax - p) / (2 * p);
                        xc2 = 2 * (nx + 1) * p;
                        if (x <= 0) xc2 = -xc2;
                    end
                end else begin
                    nx = x / p;
                    xc2 = (2 * nx + (x > 0 ? 1 : -1)) * p;
                end
                if (in_hole(2 * x - xc2, 2 * (y - yc))) begin
                    if (uz == 0) begin
                        r.action = ACT_KILL;
                    end else begin
                        t = thick;
                        az = uz < 0 ? -uz : uz;
                        xf = x + (t * ux) / az;
                        yf = y + (t * uy) / az;
                        if (in_hole(2 * xf - xc2, 2 * (yf - yc))) begin
                            r.action = ACT_PASS;
                            ox = xf; oy = yf;
                            oz = uz > 0 ? plane + t : plane - t;
                        end else begin
                            r.action = ACT_KILL;
                        end
                    end
                end
            end
            r.new_x = clamp32(ox);
            r.new_y = clamp32(oy);
            r.new_z = clamp32(oz);
            expected_q.push_back(r);
        endfunction

        function void check_result(out_t got);
            out_t e;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result beat: %p", $time, got);
                fails++;
                return;
            end
            e = expected_q.pop_front();
            checked_cnt++;
            if (e.action == ACT_PASS) passed_cnt++;
            if (e.action == ACT_KILL) killed_cnt++;
            if (got.action !== e.action) begin
                $display("%0t action: expected %0d actual %0d", $time, e.action, got.action);
                fails++;
            end
            if (got.new_x !== e.new_x) begin
                $display("%0t new_x: expected %0d actual %0d", $time, e.new_x, got.new_x);
                fails++;
            end
            if (got.new_y !== e.new_y) begin
                $display("%0t new_y: expected %0d actual %0d", $time, e.new_y, got.new_y);
                fails++;
            end
            if (got.new_z !== e.new_z) begin
                $display("%0t new_z: expected %0d actual %0d", $time, e.new_z, got.new_z);
                fails++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_t         s_payload;
    logic        m_valid;
    logic        m_ready;
    out_t        m_payload;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    transit_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off;

    hex_hole_plate_transit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("hex_hole_plate_transit verification failed");
        $finish;
    end

    // receiver: random stalls plus explicit hold-off stretches
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_payload);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_cfg(reg_idx_t idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        int n;
        n = 0;
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        while (n < 60) begin
            @(posedge aclk);
            n++;
        end
    endtask

    task automatic send_photon(in_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= b;
        sb.note_photon(b);
        do @(posedge aclk); while (!s_ready);
    endtask

    // aimed near a lattice centre, inside the z window most of the time
    function automatic in_t near_hole();
        in_t b;
        longint p, sy, row, col;
        p = sb.pitch == 0 ? 1 : sb.pitch;
        sy = (longint'(p) * 64'd929887697) >> 30;
        row = $signed($urandom_range(20)) - 10;
        col = $signed($urandom_range(20)) - 10;
        b.pos_y = 32'(row * sy + $signed($urandom_range(2 * sb.radius + 2)) - sb.radius);
        b.pos_x = 32'(col * p + (row[0] ? 0 : p / 2)
                  + $signed($urandom_range(2 * sb.radius + 2)) - sb.radius);
        if ($urandom_range(9) == 0) b.pos_z = $urandom;
        else b.pos_z = 32'(sb.plane + $signed($urandom_range(2 * sb.window)) - sb.window);
        b.dir_x = 16'($signed($urandom_range(32768)) - 16384);
        b.dir_y = 16'($signed($urandom_range(32768)) - 16384);
        b.dir_z = $urandom_range(19) == 0 ? 16'sd0
                                          : 16'($signed($urandom_range(32768)) - 16384);
        if ($urandom_range(3) == 0) b.dir_z = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        return b;
    endfunction

    function automatic in_t noise_photon();
        in_t b;
        b.pos_x = $urandom; b.pos_y = $urandom; b.pos_z = $urandom;
        b.dir_x = 16'($urandom); b.dir_y = 16'($urandom); b.dir_z = 16'($urandom);
        return b;
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(4) == 0) send_photon(noise_photon());
            else send_photon(near_hole());
        end
    endtask

    task automatic directed();
        in_t b;
        logic signed [31:0] px[6];
        logic signed [15:0] dv[5];
        px = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 29491, -29491, 100};
        dv = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd1, -16'sd1};
        for (int i = 0; i < 6; i++) begin
            b.pos_x = px[i]; b.pos_y = px[5 - i]; b.pos_z = (i == 2) ? 654 : 0;
            b.dir_x = dv[i % 5]; b.dir_y = dv[(i + 1) % 5]; b.dir_z = dv[(i + 2) % 5];
            send_photon(b);
        end
        // window edges, zero signs, center hits with each z direction
        foreach (dv[k]) begin
            b = '0;
            b.pos_x = 29491; b.dir_z = dv[k]; b.dir_x = 16'sd16384; b.dir_y = -16'sd16384;
            send_photon(b);
        end
        b = '0; b.pos_x = 29491; b.pos_z = 655; b.dir_z = 16'sd16384; send_photon(b);
        b.pos_z = -655; send_photon(b);
        b.pos_z = -654; send_photon(b);
        b = '0; b.pos_y = 51076; b.dir_z = -16'sd16384; send_photon(b);
        b.pos_y = -51076; send_photon(b);
        b.pos_x = 0; b.pos_y = 0; send_photon(b);
        b.pos_x = 32'sh8000_0000; b.pos_y = 32'sh8000_0000; send_photon(b);
    endtask

    initial begin
        sb = new();
        sb.set_reset_regs();
        aresetn = 0; s_valid = 0; s_payload = '0; m_ready = 0;
        cfg_wr_en = 0; cfg_addr = REG_HOLE_PITCH; cfg_wdata = '0;
        hold_off = 0; send_idle_pct = 8; recv_idle_pct = 61;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        directed();
        random_phase(150);
        drain();

        send_idle_pct = 61; recv_idle_pct = 8;
        write_cfg(REG_HOLE_PITCH, 32'd1);
        write_cfg(REG_HOLE_RADIUS, 32'h7FFF_FFFF);
        write_cfg(REG_PLANE_Z, 32'h8000_0000);
        write_cfg(REG_PLATE_THICKNESS, 32'h7FFF_FFFF);
        write_cfg(REG_CAPTURE_WINDOW, 32'h7FFF_FFFF);
        random_phase(60);
        drain();
        write_cfg(REG_HOLE_PITCH, 32'd0);
        write_cfg(REG_HOLE_RADIUS, 32'd0);
        write_cfg(REG_PLANE_Z, 32'h7FFF_FFFF);
        write_cfg(REG_PLATE_THICKNESS, 32'd0);
        write_cfg(REG_CAPTURE_WINDOW, 32'd0);
        random_phase(30);
        drain();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_cfg(REG_HOLE_PITCH, 32'h7FFF_FFFF);
        write_cfg(REG_HOLE_RADIUS, 32'h3FFF_FFFF);
        write_cfg(REG_PLANE_Z, 32'd0);
        write_cfg(REG_PLATE_THICKNESS, 32'd655360);
        write_cfg(REG_CAPTURE_WINDOW, 32'd65536);
        random_phase(60);
        drain();
        write_cfg(REG_HOLE_PITCH, 32'd131072);
        write_cfg(REG_HOLE_RADIUS, 32'd45000);
        write_cfg(REG_PLANE_Z, -32'sd200000);
        write_cfg(REG_PLATE_THICKNESS, 32'd20000);
        write_cfg(REG_CAPTURE_WINDOW, 32'd3000);
        hold_off = 300;
        random_phase(150);
        drain();
        random_phase(80);
        drain();

        $display("covered %0d photons: %0d passed, %0d killed, over five register settings",
                 sb.checked_cnt, sb.passed_cnt, sb.killed_cnt);
        if (sb.fails == 0) begin
            $display("hex_hole_plate_transit verification clean");
        end else begin
            $display("hex_hole_plate_transit verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
